// ===== src/u8u16_pkg.sv =====
// Shared types and constants for the UTF-8 to UTF-16 transcoder.
// No dependencies; used by every module of the block.
package u8u16_pkg;

   // widths of the stream fields
   localparam int unsigned BYTE_W     = 8;
   localparam int unsigned UNIT_W     = 16;
   localparam int unsigned CP_W       = 21;
   localparam int unsigned MAX_UNITS  = 4;

   // reset value of the replacement unit ('?')
   localparam logic [UNIT_W-1:0] REPLACEMENT_RESET = 16'd63;

   // lead byte ranges
   localparam logic [BYTE_W-1:0] LEAD2_LO = 8'hC2;
   localparam logic [BYTE_W-1:0] LEAD2_HI = 8'hDF;
   localparam logic [BYTE_W-1:0] LEAD3_LO = 8'hE0;
   localparam logic [BYTE_W-1:0] LEAD3_HI = 8'hEF;
   localparam logic [BYTE_W-1:0] LEAD4_LO = 8'hF0;
   localparam logic [BYTE_W-1:0] LEAD4_HI = 8'hF4;

   // lead bytes with a narrowed second-byte range
   localparam logic [BYTE_W-1:0] LEAD_E0 = 8'hE0;
   localparam logic [BYTE_W-1:0] LEAD_ED = 8'hED;
   localparam logic [BYTE_W-1:0] LEAD_F0 = 8'hF0;
   localparam logic [BYTE_W-1:0] LEAD_F4 = 8'hF4;

   // continuation byte bounds
   localparam logic [BYTE_W-1:0] CONT_MASK = 8'hC0;
   localparam logic [BYTE_W-1:0] CONT_LO   = 8'h80;
   localparam logic [BYTE_W-1:0] CONT_HI   = 8'hBF;
   localparam logic [BYTE_W-1:0] E0_LO     = 8'hA0;
   localparam logic [BYTE_W-1:0] ED_HI     = 8'h9F;
   localparam logic [BYTE_W-1:0] F0_LO     = 8'h90;
   localparam logic [BYTE_W-1:0] F4_HI     = 8'h8F;

   // surrogate bases
   localparam logic [UNIT_W-1:0] HIGH_SURR = 16'hD800;
   localparam logic [UNIT_W-1:0] LOW_SURR  = 16'hDC00;

   // up to four code units produced by one byte
   typedef struct packed {
      logic [2:0]                         count;
      logic                               last_flag;
      logic [MAX_UNITS-1:0][UNIT_W-1:0]   units;
   } unit_group_type;

endpackage

// ===== src/u8u16_decoder.sv =====
// Sequence state and single-pass decode of one UTF-8 byte into a unit group.
// Depends on u8u16_pkg.
module u8u16_decoder (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              advance,
   input  logic [u8u16_pkg::BYTE_W-1:0]      data_byte,
   input  logic                              end_of_string,
   input  logic [u8u16_pkg::UNIT_W-1:0]      replacement_unit,
   output u8u16_pkg::unit_group_type         group
);

   logic [u8u16_pkg::BYTE_W-1:0]  lead_ff, lead_in;
   logic [u8u16_pkg::CP_W-1:0]    partial_ff, partial_in;
   logic [1:0]                    held_ff, held_in;
   logic [2:0]                    needed_ff, needed_in;

   logic                          cont_ok;
   logic                          start_path;
   logic                          is_ascii, is_lead2, is_lead3, is_lead4;
   logic [u8u16_pkg::CP_W-1:0]    cp_next;
   logic [2:0]                    held_p1;
   logic [19:0]                   supp;
   logic [1:0]                    flush_cnt, mid_cnt, tail_cnt;
   logic [u8u16_pkg::UNIT_W-1:0]  mid0, mid1;
   logic [2:0]                    total;
   logic [2:0]                    pos;

   // continuation check, narrowed after some lead bytes
   always_comb begin
      cont_ok = (data_byte & u8u16_pkg::CONT_MASK) == u8u16_pkg::CONT_LO;
      if (held_ff == 2'd1) begin
         if (lead_ff == u8u16_pkg::LEAD_E0) begin
            cont_ok = data_byte >= u8u16_pkg::E0_LO && data_byte <= u8u16_pkg::CONT_HI;
         end else if (lead_ff == u8u16_pkg::LEAD_ED) begin
            cont_ok = data_byte >= u8u16_pkg::CONT_LO && data_byte <= u8u16_pkg::ED_HI;
         end else if (lead_ff == u8u16_pkg::LEAD_F0) begin
            cont_ok = data_byte >= u8u16_pkg::F0_LO && data_byte <= u8u16_pkg::CONT_HI;
         end else if (lead_ff == u8u16_pkg::LEAD_F4) begin
            cont_ok = data_byte >= u8u16_pkg::CONT_LO && data_byte <= u8u16_pkg::F4_HI;
         end
      end
   end

   // byte classes at a sequence start
   assign is_ascii = !data_byte[7];
   assign is_lead2 = data_byte >= u8u16_pkg::LEAD2_LO && data_byte <= u8u16_pkg::LEAD2_HI;
   assign is_lead3 = data_byte >= u8u16_pkg::LEAD3_LO && data_byte <= u8u16_pkg::LEAD3_HI;
   assign is_lead4 = data_byte >= u8u16_pkg::LEAD4_LO && data_byte <= u8u16_pkg::LEAD4_HI;

   assign start_path = (held_ff == 2'd0) || !cont_ok;
   assign cp_next    = {partial_ff[u8u16_pkg::CP_W-7:0], data_byte[5:0]};
   assign held_p1    = {1'b0, held_ff} + 3'd1;
   assign supp       = 20'(cp_next - 21'h10000);

   // next state and the units of this byte
   always_comb begin
      lead_in    = lead_ff;
      partial_in = partial_ff;
      held_in    = held_ff;
      needed_in  = needed_ff;
      flush_cnt  = 2'd0;
      mid_cnt    = 2'd0;
      mid0       = replacement_unit;
      mid1       = replacement_unit;
      tail_cnt   = 2'd0;
      if (start_path) begin
         // a broken sequence flushes its held bytes first
         flush_cnt  = held_ff;
         lead_in    = '0;
         partial_in = '0;
         held_in    = 2'd0;
         needed_in  = 3'd0;
         if (is_ascii) begin
            mid_cnt = 2'd1;
            mid0    = {8'h00, data_byte};
         end else if (is_lead2 || is_lead3 || is_lead4) begin
            lead_in = data_byte;
            held_in = 2'd1;
            if (is_lead2) begin
               partial_in = {16'h0, data_byte[4:0]};
               needed_in  = 3'd2;
            end else if (is_lead3) begin
               partial_in = {17'h0, data_byte[3:0]};
               needed_in  = 3'd3;
            end else begin
               partial_in = {18'h0, data_byte[2:0]};
               needed_in  = 3'd4;
            end
         end else begin
            mid_cnt = 2'd1;
         end
      end else if (held_p1 >= needed_ff) begin
         // sequence complete
         lead_in    = '0;
         partial_in = '0;
         held_in    = 2'd0;
         needed_in  = 3'd0;
         if (cp_next[u8u16_pkg::CP_W-1:16] == '0) begin
            mid_cnt = 2'd1;
            mid0    = cp_next[15:0];
         end else begin
            mid_cnt = 2'd2;
            mid0    = u8u16_pkg::HIGH_SURR | {6'h0, supp[19:10]};
            mid1    = u8u16_pkg::LOW_SURR | {6'h0, supp[9:0]};
         end
      end else begin
         partial_in = cp_next;
         held_in    = held_p1[1:0];
      end
      // end of string flushes whatever is still pending
      if (end_of_string) begin
         tail_cnt   = held_in;
         lead_in    = '0;
         partial_in = '0;
         held_in    = 2'd0;
         needed_in  = 3'd0;
      end
   end

   assign total = {1'b0, flush_cnt} + {1'b0, mid_cnt} + {1'b0, tail_cnt};

   // place the units: replacements around the decoded ones
   always_comb begin
      group.count     = total;
      group.last_flag = end_of_string && (total != 3'd0);
      for (int i = 0; i < u8u16_pkg::MAX_UNITS; i++) begin
         pos = 3'(i) - {1'b0, flush_cnt};
         group.units[i] = replacement_unit;
         if ((3'(i) >= {1'b0, flush_cnt}) && (pos < {1'b0, mid_cnt})) begin
            group.units[i] = pos[0] ? mid1 : mid0;
         end
      end
   end

   // sequence state
   always_ff @(posedge clock) begin
      if (reset) begin
         lead_ff    <= '0;
         partial_ff <= '0;
         held_ff    <= 2'd0;
         needed_ff  <= 3'd0;
      end else if (advance) begin
         lead_ff    <= lead_in;
         partial_ff <= partial_in;
         held_ff    <= held_in;
         needed_ff  <= needed_in;
      end
   end

endmodule

// ===== src/u8u16_unit_buffer.sv =====
// Result register holding one unit group, drained one code unit per transfer.
// Depends on u8u16_pkg.
module u8u16_unit_buffer (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              load,
   input  u8u16_pkg::unit_group_type         group,
   output logic                              free,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [u8u16_pkg::UNIT_W-1:0]      rsp_tdata,
   output logic                              rsp_tlast
);

   logic [2:0]                                          count_ff, count_in;
   logic                                                last_ff, last_in;
   logic [u8u16_pkg::MAX_UNITS-1:0][u8u16_pkg::UNIT_W-1:0] units_ff, units_in;
   logic                                                take;

   assign rsp_tvalid = count_ff != 3'd0;
   assign take       = rsp_tvalid && rsp_tready;
   assign free       = (count_ff == 3'd0) || (count_ff == 3'd1 && rsp_tready);
   assign rsp_tdata  = units_ff[0];
   assign rsp_tlast  = last_ff && (count_ff == 3'd1);

   // load a new group or shift out the unit just taken
   always_comb begin
      count_in = count_ff;
      last_in  = last_ff;
      units_in = units_ff;
      if (load) begin
         count_in = group.count;
         last_in  = group.last_flag;
         units_in = group.units;
      end else if (take) begin
         count_in = count_ff - 3'd1;
         for (int i = 0; i < u8u16_pkg::MAX_UNITS - 1; i++) begin
            units_in[i] = units_ff[i+1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 3'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      last_ff  <= last_in;
      units_ff <= units_in;
   end

endmodule

// ===== src/utf8_to_utf16_transcoder_unit.sv =====
// Top level of the UTF-8 to UTF-16 transcoder: input register, decoder, result buffer.
// Depends on u8u16_pkg, u8u16_decoder and u8u16_unit_buffer.

// Takes one UTF-8 byte per transfer on req_ (tlast marks the last byte of a
// string) and gives UTF-16 code units on rsp_ (tlast on the last unit of a
// string). Validation is strict; each byte of a malformed sequence becomes the
// replacement unit written on the csr_ port (reset value '?'), and a byte that
// breaks a sequence is decoded again as a new start. A byte is registered, then
// decoded in one pass into a group of up to four units that is loaded into the
// result register, which sends one unit per cycle while rsp_tready is high. A byte
// that yields more than one unit holds the input until its last unit is taken;
// bytes that yield one unit or none flow at one byte per cycle with rsp_tready high.
module utf8_to_utf16_transcoder_unit (
   input  logic                              clock,
   input  logic                              reset,
   // byte stream
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [7:0]                        req_tdata,   // [7:0] data_byte
   input  logic                              req_tlast,   // end_of_string
   // code unit stream
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [15:0]                       rsp_tdata,   // [15:0] code_unit
   output logic                              rsp_tlast,   // final_unit
   // replacement unit register
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [15:0]                       csr_data     // [15:0] replacement_unit
);

   logic                               in_valid_ff, in_valid_in;
   logic [u8u16_pkg::BYTE_W-1:0]       in_byte_ff;
   logic                               in_last_ff;
   logic [u8u16_pkg::UNIT_W-1:0]       repl_ff;
   logic                               buf_free;
   logic                               advance;
   u8u16_pkg::unit_group_type          group;

   // input register moves on when the result register can take its group
   assign advance     = in_valid_ff && buf_free;
   assign req_tready  = !in_valid_ff || advance;
   assign in_valid_in = (req_tvalid && req_tready) || (in_valid_ff && !advance);
   assign csr_ready   = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   // replacement unit register
   always_ff @(posedge clock) begin
      if (reset) begin
         repl_ff <= u8u16_pkg::REPLACEMENT_RESET;
      end else if (csr_valid && csr_ready) begin
         repl_ff <= csr_data;
      end
   end

   // decode
   u8u16_decoder u_decoder (
      .clock            (clock),
      .reset            (reset),
      .advance          (advance),
      .data_byte        (in_byte_ff),
      .end_of_string    (in_last_ff),
      .replacement_unit (repl_ff),
      .group            (group)
   );

   // result register
   u8u16_unit_buffer u_unit_buffer (
      .clock      (clock),
      .reset      (reset),
      .load       (advance),
      .group      (group),
      .free       (buf_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== test/tb_utf8_to_utf16_transcoder_unit.sv =====
// Self-checking testbench for utf8_to_utf16_transcoder_unit: byte stream in, code units out.
// Needs u8u16_pkg and the transcoder RTL; the expected units come from a decoder kept here.
`timescale 1ns / 1ps

module tb_utf8_to_utf16_transcoder_unit;

   typedef struct {
      bit [7:0] data;
      bit       last;
   } utf8_byte_type;

   typedef struct {
      bit [15:0] code_unit;
      bit        final_unit;
   } code_unit_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;   // [7:0] data_byte
   logic        req_tlast;   // end_of_string
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;   // [15:0] code_unit
   logic        rsp_tlast;   // final_unit
   logic        csr_valid;
   logic        csr_ready;
   logic [15:0] csr_data;    // [15:0] replacement_unit

   utf8_to_utf16_transcoder_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   // stimulus and expectation stores
   utf8_byte_type  byte_queue[$];
   code_unit_type  units_due[$];
   bit [15:0]      step_units[$];
   bit [7:0]       text_bytes[$];

   int          mismatch_count = 0;
   int          tx_idle_pct    = 0;
   int          rx_idle_pct    = 0;
   bit          long_hold_req  = 0;
   bit          byte_offered   = 0;
   bit          byte_taken     = 0;

   // decoder state, mirrors the block after reset
   bit [15:0]   repl_unit = u8u16_pkg::REPLACEMENT_RESET;
   bit [7:0]    lead_q    = '0;
   bit [20:0]   cp_acc    = '0;
   bit [1:0]    held_cnt  = '0;
   bit [2:0]    need_cnt  = '0;

   // clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // run limit
   initial begin
      #600000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // at most four units per byte
   function automatic void put_unit(bit [15:0] u);
      if (step_units.size() < u8u16_pkg::MAX_UNITS)
         step_units.insert(step_units.size(), u);
   endfunction

   function automatic void clear_held();
      lead_q   = '0;
      cp_acc   = '0;
      held_cnt = '0;
      need_cnt = '0;
   endfunction

   // held bytes turn into replacement units
   function automatic void flush_held();
      for (int i = 0; i < held_cnt; i++)
         put_unit(repl_unit);
      clear_held();
   endfunction

   // byte seen with no sequence pending
   function automatic void start_byte(bit [7:0] b);
      if (b < u8u16_pkg::CONT_LO) begin
         put_unit({8'h00, b});
      end else if (b >= u8u16_pkg::LEAD2_LO && b <= u8u16_pkg::LEAD2_HI) begin
         lead_q = b; cp_acc = {16'b0, b[4:0]}; held_cnt = 2'd1; need_cnt = 3'd2;
      end else if (b >= u8u16_pkg::LEAD3_LO && b <= u8u16_pkg::LEAD3_HI) begin
         lead_q = b; cp_acc = {17'b0, b[3:0]}; held_cnt = 2'd1; need_cnt = 3'd3;
      end else if (b >= u8u16_pkg::LEAD4_LO && b <= u8u16_pkg::LEAD4_HI) begin
         lead_q = b; cp_acc = {18'b0, b[2:0]}; held_cnt = 2'd1; need_cnt = 3'd4;
      end else begin
         put_unit(repl_unit);
      end
   endfunction

   // one accepted byte: update state, queue the code units it yields
   function automatic void decode_byte(bit [7:0] b, bit eos);
      bit            fits;
      bit [20:0]     cp;
      bit [19:0]     offs;
      code_unit_type e;
      step_units.delete();
      if (held_cnt == 0) begin
         start_byte(b);
      end else begin
         fits = (b & u8u16_pkg::CONT_MASK) == u8u16_pkg::CONT_LO;
         // narrowed second byte after some lead bytes
         if (held_cnt == 1) begin
            case (lead_q)
               u8u16_pkg::LEAD_E0: fits = (b >= u8u16_pkg::E0_LO && b <= u8u16_pkg::CONT_HI);
               u8u16_pkg::LEAD_ED: fits = (b >= u8u16_pkg::CONT_LO && b <= u8u16_pkg::ED_HI);
               u8u16_pkg::LEAD_F0: fits = (b >= u8u16_pkg::F0_LO && b <= u8u16_pkg::CONT_HI);
               u8u16_pkg::LEAD_F4: fits = (b >= u8u16_pkg::CONT_LO && b <= u8u16_pkg::F4_HI);
               default: ;
            endcase
         end
         if (fits) begin
            cp_acc = {cp_acc[14:0], b[5:0]};
            if (int'(held_cnt) + 1 >= int'(need_cnt)) begin
               cp = cp_acc;
               clear_held();
               if (cp <= 21'h00FFFF) begin
                  put_unit(cp[15:0]);
               end else begin
                  offs = 20'(cp - 21'h010000);
                  put_unit(u8u16_pkg::HIGH_SURR + {6'b0, offs[19:10]});
                  put_unit(u8u16_pkg::LOW_SURR + {6'b0, offs[9:0]});
               end
            end else begin
               held_cnt = held_cnt + 2'd1;
            end
         end else begin
            // broken sequence, then the breaking byte starts anew
            flush_held();
            start_byte(b);
         end
      end
      if (eos)
         flush_held();
      foreach (step_units[i]) begin
         e.code_unit  = step_units[i];
         e.final_unit = eos && (i == step_units.size() - 1);
         units_due.insert(units_due.size(), e);
      end
   endfunction

   // check outgoing units, predict on incoming bytes
   always @(posedge clock) begin : check_and_predict
      code_unit_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (units_due.size() == 0) begin
               $display("%0t: unexpected code unit, expected none, got %h last %b",
                        $time, rsp_tdata, rsp_tlast);
               mismatch_count++;
            end else begin
               want = units_due.pop_front();
               if (want.code_unit !== rsp_tdata || want.final_unit !== rsp_tlast) begin
                  $display("%0t: code unit mismatch, expected %h last %b, got %h last %b",
                           $time, want.code_unit, want.final_unit, rsp_tdata, rsp_tlast);
                  mismatch_count++;
               end
            end
         end
         if (req_tvalid && req_tready)
            decode_byte(req_tdata, req_tlast);
      end
      byte_taken <= !reset && req_tvalid && req_tready;
   end

   // byte driver, fed from byte_queue
   always @(negedge clock) begin : byte_driver
      utf8_byte_type nxt;
      if (byte_offered && byte_taken)
         byte_offered = 1'b0;
      if (!byte_offered) begin
         if (!reset && byte_queue.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
            nxt = byte_queue.pop_front();
            req_tdata    <= nxt.data;
            req_tlast    <= nxt.last;
            req_tvalid   <= 1'b1;
            byte_offered = 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // unit receiver with random stalls and one long hold-off
   always @(negedge clock) begin : unit_receiver
      int hold_left;
      if (long_hold_req && hold_left == 0) begin
         hold_left     = 300;
         long_hold_req = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
   end

   task automatic push_byte(input bit [7:0] data, input bit last);
      utf8_byte_type it;
      it.data = data;
      it.last = last;
      byte_queue.insert(byte_queue.size(), it);
   endtask

   task automatic write_replacement(input bit [15:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      repl_unit = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // all bytes sent, all units seen, then a pause for lead bytes still in flight
   task automatic wait_drained();
      while (byte_queue.size() != 0 || byte_offered || units_due.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // code point biased toward encoding boundaries
   function automatic bit [20:0] random_code_point();
      bit [20:0] edges[15] = '{21'h7F, 21'h80, 21'h7FF, 21'h800, 21'hFFF, 21'h1000,
                               21'hD7FF, 21'hE000, 21'hFFFF, 21'h10000, 21'h3FFFF,
                               21'h40000, 21'hFFFFF, 21'h100000, 21'h10FFFF};
      bit [20:0] cp;
      case ($urandom_range(0, 9))
         0, 1, 2: cp = 21'($urandom_range(0, 21'h7F));
         3, 4:    cp = 21'($urandom_range(21'h80, 21'h7FF));
         5, 6, 7: begin
            cp = 21'($urandom_range(21'h800, 21'hFFFF));
            if (cp >= 21'hD800 && cp <= 21'hDFFF)
               cp = cp ^ 21'h2000;
         end
         8:       cp = edges[$urandom_range(0, 14)];
         default: cp = 21'($urandom_range(21'h10000, 21'h10FFFF));
      endcase
      return cp;
   endfunction

   function automatic void encode_utf8(bit [20:0] cp);
      if (cp < 21'h80) begin
         text_bytes.insert(text_bytes.size(), cp[7:0]);
      end else if (cp < 21'h800) begin
         text_bytes.insert(text_bytes.size(), {3'b110, cp[10:6]});
         text_bytes.insert(text_bytes.size(), {2'b10, cp[5:0]});
      end else if (cp < 21'h10000) begin
         text_bytes.insert(text_bytes.size(), {4'b1110, cp[15:12]});
         text_bytes.insert(text_bytes.size(), {2'b10, cp[11:6]});
         text_bytes.insert(text_bytes.size(), {2'b10, cp[5:0]});
      end else begin
         text_bytes.insert(text_bytes.size(), {5'b11110, cp[20:18]});
         text_bytes.insert(text_bytes.size(), {2'b10, cp[17:12]});
         text_bytes.insert(text_bytes.size(), {2'b10, cp[11:6]});
         text_bytes.insert(text_bytes.size(), {2'b10, cp[5:0]});
      end
   endfunction

   // strings of mostly well-formed characters, some cut short, corrupted or raw noise
   task automatic queue_random_text(input int target);
      int pushed;
      int n_chars;
      int first;
      int len;
      int pick;
      pushed = 0;
      while (pushed < target) begin
         text_bytes.delete();
         n_chars = $urandom_range(1, 8);
         repeat (n_chars) begin
            first = text_bytes.size();
            pick  = $urandom_range(0, 99);
            if (pick < 88) begin
               encode_utf8(random_code_point());
               len = text_bytes.size() - first;
               if (pick >= 70 && pick < 80 && len > 1) begin
                  repeat ($urandom_range(1, len - 1)) void'(text_bytes.pop_back());
               end else if (pick >= 80 && len > 1) begin
                  text_bytes[first + $urandom_range(1, len - 1)] = 8'($urandom_range(0, 255));
               end
            end else begin
               text_bytes.insert(text_bytes.size(), 8'($urandom_range(0, 255)));
            end
         end
         foreach (text_bytes[i])
            push_byte(text_bytes[i], i == text_bytes.size() - 1);
         pushed += text_bytes.size();
      end
   endtask

   // main sequence
   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tlast  = 1'b0;
      rsp_tready = 1'b0;
      csr_valid  = 1'b0;
      csr_data   = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed bytes at the reset replacement unit
      tx_idle_pct = 22;
      rx_idle_pct = 78;
      // ascii extremes, zero byte, invalid lead bytes
      push_byte(8'h00, 1'b0);
      push_byte(8'h7F, 1'b1);
      push_byte(8'h80, 1'b0);
      push_byte(8'hC1, 1'b0);
      push_byte(8'hF5, 1'b0);
      push_byte(8'hFF, 1'b0);
      // largest two-byte form
      push_byte(8'hDF, 1'b0);
      push_byte(8'hBF, 1'b0);
      // narrowed second byte violated after E0, ED and F0
      push_byte(8'hE0, 1'b0);
      push_byte(8'h9F, 1'b0);
      push_byte(8'hED, 1'b0);
      push_byte(8'hA0, 1'b0);
      push_byte(8'hF0, 1'b0);
      push_byte(8'h8F, 1'b0);
      // U+10FFFF as a surrogate pair, ending the string
      push_byte(8'hF4, 1'b0);
      push_byte(8'h8F, 1'b0);
      push_byte(8'hBF, 1'b0);
      push_byte(8'hBF, 1'b1);
      // zero byte cutting a sequence short
      push_byte(8'hE2, 1'b0);
      push_byte(8'h82, 1'b0);
      push_byte(8'h00, 1'b0);
      // end of string with three bytes held
      push_byte(8'hF1, 1'b0);
      push_byte(8'h80, 1'b0);
      push_byte(8'h80, 1'b1);
      wait_drained();

      write_replacement(16'hFFFD);
      queue_random_text(170);
      wait_drained();

      tx_idle_pct = 78;
      rx_idle_pct = 22;
      write_replacement(16'h0000);
      queue_random_text(170);
      wait_drained();

      // no idling; receiver holds off long enough to back up the input
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      write_replacement(16'hFFFF);
      queue_random_text(170);
      @(posedge clock);
      long_hold_req = 1'b1;
      wait_drained();

      if (mismatch_count == 0 && units_due.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
